// ===== design/ignition_delay_relay_guard_defines.svh =====
// Assertion macros shared by the checker of the relay guard.
// No dependencies; include by bare file name.
`ifndef IGNITION_DELAY_RELAY_GUARD_DEFINES_SVH
`define IGNITION_DELAY_RELAY_GUARD_DEFINES_SVH

// Consequent must hold on the same edge as the antecedent.
`define IDRG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define IDRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/idrg_pkg.sv =====
// Shared widths, register indexes, reset values and types of the relay guard.
// No dependencies.
package idrg_pkg;

    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned MV_W       = 15;
    localparam int unsigned GAIN_W     = 20;
    localparam int unsigned OFFSET_W   = 12;
    localparam int unsigned PERIOD_W   = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned GAIN_FRAC  = 16;

    localparam int unsigned WINDOW_DEF = 10;

    localparam logic [MV_W-1:0] BATT_MAX = '1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BATT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd5;

    localparam logic [HOLD_W-1:0]   HOLD_ONE_RST = 16'd60;
    localparam logic [HOLD_W-1:0]   HOLD_TWO_RST = 16'd60;
    localparam logic [MV_W-1:0]     MIN_BATT_RST = 15'd10000;
    localparam logic [GAIN_W-1:0]   GAIN_RST     = 20'd293091;
    localparam logic [OFFSET_W-1:0] OFFSET_RST   = 12'd800;
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 8'd10;

    // window stage control from the top level
    typedef struct packed {
        logic load;   // input beat accepted, read old entry
        logic adv;    // window stage hands its item on, write back
    } t_win_ctl;

endpackage

// ===== design/ignition_delay_relay_guard.sv =====
// Ignition delay-off relay guard with low-voltage disconnect, top level.
// Depends on idrg_pkg and idrg_window.
//
//  channel   valid          stall          payload
//  -------   ------------   ------------   ---------------------------------------------
//  in        i_in_valid     o_in_stall     i_ignition_on, i_sense_mv
//  out       o_out_valid    i_out_stall    o_relay_one_on .. o_periodic_report
//  cfg       i_cfg_we       (none)         i_cfg_idx, i_cfg_data
//
// One beat per cycle sustained while i_out_stall stays low; each beat is registered through
// window memory read, sum update, gain multiply, reciprocal multiply,
// quotient correction, then relay update into the output register.
// Synchronous active-low reset; no clearing pass, the first sample stands in
// for window entries not yet written. A stalled result holds in the output
// register while earlier stages keep filling their empty slots.
module ignition_delay_relay_guard #(
    parameter int unsigned WINDOW = idrg_pkg::WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [idrg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [idrg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_ignition_on,
    input  logic [idrg_pkg::SAMPLE_W-1:0]     i_sense_mv,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_relay_one_on,
    output logic                              o_relay_two_on,
    output logic [idrg_pkg::MV_W-1:0]         o_battery_mv,
    output logic                              o_window_full,
    output logic                              o_under_voltage,
    output logic                              o_final_report,
    output logic                              o_periodic_report
);
    import idrg_pkg::*;

    localparam int unsigned SUM_W  = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
    localparam int unsigned PROD_W = SUM_W + GAIN_W;
    localparam int unsigned X_W    = PROD_W - GAIN_FRAC;
    localparam int unsigned WIN_W  = $clog2(WINDOW + 1);
    localparam logic [X_W-1:0] RECIP = X_W'((64'd1 << X_W) / WINDOW);

    // configuration
    logic [HOLD_W-1:0]   r_hold_one;
    logic [HOLD_W-1:0]   r_hold_two;
    logic [MV_W-1:0]     r_min_batt;
    logic [GAIN_W-1:0]   r_gain;
    logic [OFFSET_W-1:0] r_offset;
    logic [PERIOD_W-1:0] r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_one <= HOLD_ONE_RST;
            r_hold_two <= HOLD_TWO_RST;
            r_min_batt <= MIN_BATT_RST;
            r_gain     <= GAIN_RST;
            r_offset   <= OFFSET_RST;
            r_period   <= PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HOLD_ONE: r_hold_one <= i_cfg_data[HOLD_W-1:0];
                CFG_HOLD_TWO: r_hold_two <= i_cfg_data[HOLD_W-1:0];
                CFG_MIN_BATT: r_min_batt <= i_cfg_data[MV_W-1:0];
                CFG_GAIN:     r_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_OFFSET:   r_offset   <= i_cfg_data[OFFSET_W-1:0];
                CFG_PERIOD:   r_period   <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and flow control
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_out_valid;
    logic free_out, free1, free2, free3, free4, free5;
    logic adv1, adv2, adv3, adv4, adv5;
    logic accept;

    always_comb begin
        free_out = !r_out_valid || !i_out_stall;
        adv5     = r_v5 && free_out;
        free5    = !r_v5 || free_out;
        adv4     = r_v4 && free5;
        free4    = !r_v4 || free5;
        adv3     = r_v3 && free4;
        free3    = !r_v3 || free4;
        adv2     = r_v2 && free3;
        free2    = !r_v2 || free3;
        adv1     = r_v1 && free2;
        free1    = !r_v1 || free2;
        accept   = i_in_valid && free1;
    end

    assign o_in_stall  = !free1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1        <= accept || (r_v1 && !adv1);
            r_v2        <= adv1   || (r_v2 && !adv2);
            r_v3        <= adv2   || (r_v3 && !adv3);
            r_v4        <= adv3   || (r_v4 && !adv4);
            r_v5        <= adv4   || (r_v5 && !adv5);
            r_out_valid <= adv5   || (r_out_valid && i_out_stall);
        end
    end

    // window stage
    t_win_ctl         win_ctl;
    logic             win_full_next;
    logic [SUM_W-1:0] win_sum;

    assign win_ctl.load = accept;
    assign win_ctl.adv  = adv1;

    idrg_window #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (win_ctl),
        .i_sample    (i_sense_mv),
        .o_full_next (win_full_next),
        .o_sum       (win_sum)
    );

    // tags and arithmetic down the stages
    logic              r_s1_ign, r_s1_full;
    logic              r_s2_ign, r_s2_full;
    logic              r_s3_ign, r_s3_full;
    logic              r_s4_ign, r_s4_full;
    logic              r_s5_ign, r_s5_full;
    logic [PROD_W-1:0] r_s3_prod;
    logic [X_W-1:0]    r_s4_x;
    logic [2*X_W-1:0]  r_s4_qm;
    logic [X_W-1:0]    r_s5_q;

    logic [X_W-1:0]    x;
    logic [X_W-1:0]    q0;
    logic [X_W+WIN_W-1:0] q0w;
    logic [X_W:0]      rem;

    always_comb begin
        x   = r_s3_prod[PROD_W-1:GAIN_FRAC];
        q0  = r_s4_qm[2*X_W-1:X_W];
        q0w = (X_W+WIN_W)'(q0) * (X_W+WIN_W)'(WINDOW);
        rem = {1'b0, r_s4_x} - q0w[X_W:0];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ign  <= i_ignition_on;
            r_s1_full <= win_full_next;
        end
        if (adv1) begin
            r_s2_ign  <= r_s1_ign;
            r_s2_full <= r_s1_full;
        end
        if (adv2) begin
            r_s3_ign  <= r_s2_ign;
            r_s3_full <= r_s2_full;
            r_s3_prod <= PROD_W'(win_sum) * PROD_W'(r_gain);
        end
        if (adv3) begin
            r_s4_ign  <= r_s3_ign;
            r_s4_full <= r_s3_full;
            r_s4_x    <= x;
            r_s4_qm   <= (2*X_W)'(x) * (2*X_W)'(RECIP);
        end
        if (adv4) begin
            r_s5_ign  <= r_s4_ign;
            r_s5_full <= r_s4_full;
            // reciprocal estimate is short by at most one
            r_s5_q    <= (rem >= (X_W+1)'(WINDOW)) ? q0 + 1'b1 : q0;
        end
    end

    // relay and report update on the way into the output register
    logic [HOLD_W-1:0]   r_hold_one_left, r_hold_two_left;
    logic                r_relay_one, r_relay_two;
    logic                r_final_sent;
    logic [PERIOD_W-1:0] r_report_cnt;
    logic [MV_W-1:0]     r_batt;
    logic                r_full, r_under, r_final, r_periodic;

    logic [X_W:0]        total;
    logic [MV_W-1:0]     batt;
    logic                under;
    logic [HOLD_W-1:0]   n_hold_one_left, n_hold_two_left;
    logic                n_relay_one, n_relay_two;
    logic                n_final_sent, final_flag;
    logic [PERIOD_W-1:0] n_report_cnt, cnt_inc;
    logic                periodic;

    always_comb begin
        total = (X_W+1)'(r_s5_q) + (X_W+1)'(r_offset);
        batt  = (total > (X_W+1)'(BATT_MAX)) ? BATT_MAX : total[MV_W-1:0];
        under = r_s5_full && (batt < r_min_batt);

        n_hold_one_left = r_hold_one_left;
        n_hold_two_left = r_hold_two_left;
        n_relay_one     = r_relay_one;
        n_relay_two     = r_relay_two;
        if (r_s5_ign) begin
            n_relay_one     = 1'b1;
            n_relay_two     = 1'b1;
            n_hold_one_left = r_hold_one;
            n_hold_two_left = r_hold_two;
        end else begin
            if (r_hold_one_left != '0) begin
                n_hold_one_left = r_hold_one_left - 1'b1;
            end
            if (r_hold_two_left != '0) begin
                n_hold_two_left = r_hold_two_left - 1'b1;
            end
            if (n_hold_one_left == '0) begin
                n_relay_one = 1'b0;
            end
            if (n_hold_two_left == '0) begin
                n_relay_two = 1'b0;
            end
        end
        // low battery overrides ignition
        if (under) begin
            n_relay_one = 1'b0;
            n_relay_two = 1'b0;
        end

        final_flag = 1'b0;
        if (!r_s5_ign && !n_relay_one && !n_relay_two) begin
            final_flag   = !r_final_sent;
            n_final_sent = 1'b1;
        end else begin
            n_final_sent = 1'b0;
        end

        cnt_inc  = r_report_cnt + 1'b1;
        periodic = (cnt_inc >= r_period);
        n_report_cnt = periodic ? '0 : cnt_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_one_left <= '0;
            r_hold_two_left <= '0;
            r_relay_one     <= 1'b0;
            r_relay_two     <= 1'b0;
            r_final_sent    <= 1'b0;
            r_report_cnt    <= '0;
        end else if (adv5) begin
            r_hold_one_left <= n_hold_one_left;
            r_hold_two_left <= n_hold_two_left;
            r_relay_one     <= n_relay_one;
            r_relay_two     <= n_relay_two;
            r_final_sent    <= n_final_sent;
            r_report_cnt    <= n_report_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv5) begin
            r_batt     <= batt;
            r_full     <= r_s5_full;
            r_under    <= under;
            r_final    <= final_flag;
            r_periodic <= periodic;
        end
    end

    assign o_relay_one_on    = r_relay_one;
    assign o_relay_two_on    = r_relay_two;
    assign o_battery_mv      = r_batt;
    assign o_window_full     = r_full;
    assign o_under_voltage   = r_under;
    assign o_final_report    = r_final;
    assign o_periodic_report = r_periodic;

endmodule

// ===== design/idrg_window.sv =====
// Sample window of the relay guard: sample memory, write slot and running sum.
// Depends on idrg_pkg.
module idrg_window #(
    parameter int unsigned WINDOW = idrg_pkg::WINDOW_DEF,
    parameter int unsigned SUM_W  = $clog2(WINDOW * ((1 << idrg_pkg::SAMPLE_W) - 1) + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  idrg_pkg::t_win_ctl                i_ctl,
    input  logic [idrg_pkg::SAMPLE_W-1:0]     i_sample,
    output logic                              o_full_next,
    output logic [SUM_W-1:0]                  o_sum
);
    import idrg_pkg::*;

    localparam int unsigned SLOT_W = $clog2(WINDOW);

    logic [SAMPLE_W-1:0] r_mem [WINDOW];
    logic [SAMPLE_W-1:0] r_rd_q;

    logic [SLOT_W-1:0]   r_slot;
    logic                r_primed;
    logic                r_filled;
    logic [SAMPLE_W-1:0] r_first;
    logic [SUM_W-1:0]    r_sum;

    logic [SLOT_W-1:0]   r_s1_slot;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic                r_s1_init;
    logic                r_s1_mem;

    logic                wrap;
    logic [SUM_W-1:0]    base;
    logic [SAMPLE_W-1:0] old;
    logic [SUM_W-1:0]    n_sum;

    assign wrap        = (r_slot == SLOT_W'(WINDOW - 1));
    assign o_full_next = r_filled | wrap;
    assign o_sum       = r_sum;

    // Until the window has wrapped, each slot not yet written counts as holding the first sample.
    always_comb begin
        base  = r_s1_init ? SUM_W'(WINDOW) * SUM_W'(r_s1_sample) : r_sum;
        old   = r_s1_mem ? r_rd_q : r_first;
        n_sum = base - SUM_W'(old) + SUM_W'(r_s1_sample);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_mem[r_s1_slot] <= r_s1_sample;
        end
        if (i_ctl.load) begin
            r_rd_q <= r_mem[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_s1_slot   <= r_slot;
            r_s1_sample <= i_sample;
            r_s1_init   <= !r_primed;
            r_s1_mem    <= r_filled;
            if (!r_primed) begin
                r_first <= i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_primed <= 1'b0;
            r_filled <= 1'b0;
            r_sum    <= '0;
        end else begin
            if (i_ctl.load) begin
                r_primed <= 1'b1;
                r_slot   <= wrap ? '0 : r_slot + 1'b1;
                if (wrap) begin
                    r_filled <= 1'b1;
                end
            end
            if (i_ctl.adv) begin
                r_sum <= n_sum;
            end
        end
    end

endmodule

// ===== design/idrg_checker.sv =====
// Port-level checks of the relay guard, bound to the top level.
// Depends on ignition_delay_relay_guard_defines.svh and idrg_pkg.
`include "ignition_delay_relay_guard_defines.svh"

module idrg_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic                              o_relay_one_on,
    input  logic                              o_relay_two_on,
    input  logic [idrg_pkg::MV_W-1:0]         o_battery_mv,
    input  logic                              o_window_full,
    input  logic                              o_under_voltage,
    input  logic                              o_final_report
);

    // low battery drops both relays in the same beat
    `IDRG_ASSERT_SAME(a_under_drops, i_clk, i_rst_n,
        o_out_valid && o_under_voltage, !o_relay_one_on && !o_relay_two_on,
        "under-voltage beat with a relay on")

    `IDRG_ASSERT_SAME(a_under_full, i_clk, i_rst_n,
        o_out_valid && o_under_voltage, o_window_full,
        "under-voltage before the window filled")

    `IDRG_ASSERT_SAME(a_final_off, i_clk, i_rst_n,
        o_out_valid && o_final_report, !o_relay_one_on && !o_relay_two_on,
        "final report with a relay on")

    `IDRG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall,
        o_out_valid && $stable(o_battery_mv) && $stable(o_relay_one_on)
            && $stable(o_relay_two_on) && $stable(o_final_report),
        "stalled result beat changed")

endmodule

bind ignition_delay_relay_guard idrg_checker u_idrg_checker (.*);
